/* rtl/smbg_pkg.sv */
// ----------------------------------------------------------------------------
// smbg_pkg
// Shared constants and types for the spectral mask bin gain pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package smbg_pkg;

    localparam int CANVAS_WIDTH   = 64;
    localparam int CANVAS_HEIGHT  = 64;
    localparam int TRANSFORM_SIZE = 2048;

    localparam int CELL_TOTAL = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int HALF_SIZE  = TRANSFORM_SIZE / 2;
    localparam int GAIN_DEPTH = HALF_SIZE + 1;

    localparam int CELL_AW = $clog2(CELL_TOTAL);
    localparam int GAIN_AW = $clog2(GAIN_DEPTH);
    localparam int COL_W   = $clog2(CANVAS_WIDTH);
    localparam int ROW_W   = $clog2(CANVAS_HEIGHT);
    localparam int CNT_W   = $clog2(CELL_TOTAL + 1);

    localparam int IDX_W = 12;
    localparam int Q15_W = 16;
    localparam int BIN_W = 11;
    localparam int POS_W = 16;

    localparam logic [Q15_W-1:0] UNITY_Q15  = 16'd32768;
    localparam logic [Q15_W-1:0] SMOOTH_Q16 = 16'd22938;
    localparam logic [Q15_W-1:0] KEEP_Q16   = 16'd42598;

    // normalised frequency bin * 2^32 / HALF_SIZE, HALF_SIZE a power of two
    localparam int FQ_SHIFT = 32 - $clog2(HALF_SIZE);

    // square root: 17 result bits, two per stage
    localparam int SQRT_STEPS     = 17;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
    localparam int ROOT_W         = SQRT_STEPS;
    localparam int REM_W          = ROOT_W + 4;
    localparam int RAD_W          = 2 * SQRT_STEPS;

    localparam int CLEAR_LEN = (CELL_TOTAL > GAIN_DEPTH) ? CELL_TOTAL : GAIN_DEPTH;
    localparam int CLR_W     = $clog2(CLEAR_LEN);

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_COMPUTE = 1'b1
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [IDX_W-1:0]  cell_index;
        logic [Q15_W-1:0]  cell_value;
        logic [BIN_W-1:0]  bin;
        logic [Q15_W-1:0]  depth;
        logic [POS_W-1:0]  scan;
    } item_t;

    typedef struct packed {
        item_t             item;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sqrt_t;

    typedef struct packed {
        logic              valid;
        logic [BIN_W-1:0]  bin;
        logic [Q15_W-1:0]  depth;
        logic [Q15_W-1:0]  mask;
        logic              nonempty;
    } mask_t;

    typedef struct packed {
        logic              valid;
        logic [BIN_W-1:0]  bin;
        logic [Q15_W-1:0]  gain;
    } result_t;

    typedef struct packed {
        logic              active;
        logic [CLR_W-1:0]  addr;
    } clear_t;

endpackage

`default_nettype wire

/* rtl/spectral_mask_bin_gain.sv */
// ----------------------------------------------------------------------------
// spectral_mask_bin_gain
// Mask canvas with bilinear sampling and per-bin smoothed gain, pipelined.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                      | tuser
//  s_axis   | in  | cell_index, cell_value, bin_index,         | op
//           |     | mask_depth, scan_position                  |
//  m_axis   | out | gain_bin, bin_gain                         | -
//
//  One request per cycle while s_axis_tready is high; a compute request
//  yields one result on m_axis, a write request yields none. A result passes
//  the input register, the 9-stage square root, sampler stages A to F, gain
//  stages G and H and the output buffer. After reset a clearing pass zeroes
//  the canvas and sets every gain to unity; s_axis_tready stays low until it ends.
//  A two-entry output buffer lets requests enter while a result waits; the
//  pipeline stalls as a whole only when that buffer is full.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_mask_bin_gain
    import smbg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] cell_index, [27:12] cell_value, [38:28] bin_index,
    // [54:39] mask_depth, [70:55] scan_position, [71] zero
    input  wire logic [71:0] s_axis_tdata,
    // [0] op
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] gain_bin, [26:11] bin_gain, [31:27] zero
    output logic [31:0]      m_axis_tdata
);

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] gain;
    } out_entry_t;

    logic             clear_active_reg;
    logic [CLR_W-1:0] clear_cnt_reg;
    clear_t           clear;
    logic             en;
    item_t            in_item;
    sqrt_t            sqrt_out;
    mask_t            mask_out;
    result_t          result;

    out_entry_t       fifo_reg [2];
    logic             fifo_wr_ptr_reg;
    logic             fifo_rd_ptr_reg;
    logic [1:0]       fifo_cnt_reg;
    logic             push;
    logic             pop;

    assign en            = (fifo_cnt_reg != 2'd2) || m_axis_tready;
    assign s_axis_tready = en && !clear_active_reg;

    assign clear.active = clear_active_reg;
    assign clear.addr   = clear_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == CLR_W'(CLEAR_LEN - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        in_item.valid      = s_axis_tvalid && s_axis_tready;
        in_item.op         = op_t'(s_axis_tuser[0]);
        in_item.cell_index = s_axis_tdata[11:0];
        in_item.cell_value = s_axis_tdata[27:12];
        in_item.bin        = s_axis_tdata[38:28];
        in_item.depth      = s_axis_tdata[54:39];
        in_item.scan       = s_axis_tdata[70:55];
    end

    smbg_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_item   (in_item),
        .out_stage (sqrt_out)
    );

    smbg_mask_sampler u_sampler (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .clear    (clear),
        .in_stage (sqrt_out),
        .out_mask (mask_out)
    );

    smbg_gain_update u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .clear      (clear),
        .in_mask    (mask_out),
        .out_result (result)
    );

    // output buffer
    assign push = en && result.valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
            fifo_cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_wr_ptr_reg <= ~fifo_wr_ptr_reg;
            end
            if (pop)
            begin
                fifo_rd_ptr_reg <= ~fifo_rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[fifo_wr_ptr_reg] <= '{bin: result.bin, gain: result.gain};
        end
    end

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = {5'b0, fifo_reg[fifo_rd_ptr_reg].gain,
                            fifo_reg[fifo_rd_ptr_reg].bin};

    a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_fifo_pop : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (fifo_cnt_reg == $past(fifo_cnt_reg) - 2'd1))
        else $error("output buffer lost track on pop");

    a_fifo_push : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fifo_cnt_reg == $past(fifo_cnt_reg) + 2'd1))
        else $error("output buffer lost track on push");

    a_clear_once : assert property (@(posedge clk) disable iff (!rst_n)
        !clear_active_reg |=> !clear_active_reg)
        else $error("clearing pass restarted");

endmodule

`default_nettype wire

/* rtl/smbg_ram.sv */
// ----------------------------------------------------------------------------
// smbg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/smbg_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// smbg_sqrt_pipe
// Input register and pipelined digit-by-digit square root of the bin's
// normalised frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module smbg_sqrt_pipe
    import smbg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire item_t in_item,
    output sqrt_t      out_stage
);

    sqrt_t stage_reg [SQRT_STAGES+1];
    sqrt_t stage0_next;

    function automatic sqrt_t sqrt_step(sqrt_t s, int j);
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sqrt_t            r;
        rad    = RAD_W'(s.item.bin) << FQ_SHIFT;
        rem_sh = {s.rem[REM_W-3:0], rad[2*j +: 2]};
        trial  = REM_W'({s.root, 2'b01});
        r      = s;
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        stage0_next      = '0;
        stage0_next.item = in_item;
        if (in_item.cell_value > UNITY_Q15)
        begin
            stage0_next.item.cell_value = UNITY_Q15;
        end
        if (in_item.bin > BIN_W'(HALF_SIZE))
        begin
            stage0_next.item.bin = BIN_W'(HALF_SIZE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg[0] <= '0;
        end
        else if (en)
        begin
            stage_reg[0] <= stage0_next;
        end
    end

    for (genvar s = 1; s <= SQRT_STAGES; s++)
    begin : g_stage
        sqrt_t nxt;

        always_comb
        begin
            nxt = stage_reg[s-1];
            for (int k = 0; k < SQRT_PER_STAGE; k++)
            begin
                if ((s - 1) * SQRT_PER_STAGE + k < SQRT_STEPS)
                begin
                    nxt = sqrt_step(nxt, SQRT_STEPS - 1 - ((s - 1) * SQRT_PER_STAGE + k));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[s] <= '0;
            end
            else if (en)
            begin
                stage_reg[s] <= nxt;
            end
        end
    end

    assign out_stage = stage_reg[SQRT_STAGES];

endmodule

`default_nettype wire

/* rtl/smbg_mask_sampler.sv */
// ----------------------------------------------------------------------------
// smbg_mask_sampler
// Canvas storage, non-zero cell count and the bilinear mask sample.
// ----------------------------------------------------------------------------
`default_nettype none

module smbg_mask_sampler
    import smbg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire clear_t clear,
    input  wire sqrt_t  in_stage,
    output mask_t       out_mask
);

    localparam int YQ_W = ROOT_W + ROW_W;
    localparam int XQ_W = POS_W + COL_W;

    typedef struct packed {
        logic             valid;
        op_t              op;
        logic             wr_hit;
        logic [CELL_AW-1:0] cell_addr;
        logic [Q15_W-1:0] cell_value;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] depth;
        logic [ROW_W-1:0] y0;
        logic [15:0]      yf;
        logic [COL_W-1:0] x0;
        logic [15:0]      xf;
    } coord_t;

    typedef struct packed {
        logic             valid;
        op_t              op;
        logic             wr_hit;
        logic             wr_nonzero;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] depth;
        logic [15:0]      yf;
        logic [15:0]      xf;
    } fetch_t;

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] depth;
        logic             nonempty;
        logic [15:0]      yf;
        logic [32:0]      p00;
        logic [32:0]      p01;
        logic [32:0]      p10;
        logic [32:0]      p11;
    } prod_t;

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] depth;
        logic             nonempty;
        logic [15:0]      yf;
        logic [31:0]      upper;
        logic [31:0]      lower;
    } rowsum_t;

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] depth;
        logic             nonempty;
        logic [48:0]      e0;
        logic [48:0]      e1;
    } blend_t;

    coord_t  a_reg,  a_next;
    fetch_t  b_reg,  b_next;
    prod_t   c_reg,  c_next;
    rowsum_t d_reg,  d_next;
    blend_t  e_reg,  e_next;
    mask_t   f_reg,  f_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [16:0]        c_root;
    logic [YQ_W-1:0]    yq;
    logic [XQ_W-1:0]    xq;
    logic [ROW_W:0]     y0_full;
    logic [ROW_W-1:0]   y1;
    logic [COL_W-1:0]   x1;
    logic [CELL_AW-1:0] rd_addr [4];
    logic [Q15_W-1:0]   rd_data [4];
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [Q15_W-1:0]   wr_data;
    logic [16:0]        wx0;
    logic [16:0]        wy0;
    logic [49:0]        m_sum;
    logic [17:0]        m_full;

    // stage A: row and column coordinates
    always_comb
    begin
        c_root = (in_stage.root > 17'd65536) ? 17'd65536 : in_stage.root;
        yq     = YQ_W'(17'd65536 - c_root) * YQ_W'(CANVAS_HEIGHT - 1);
        xq     = XQ_W'(in_stage.item.scan) * XQ_W'(CANVAS_WIDTH);
        y0_full = yq[YQ_W-1:16];

        a_next            = '0;
        a_next.valid      = in_stage.item.valid;
        a_next.op         = in_stage.item.op;
        a_next.wr_hit     = ({1'b0, in_stage.item.cell_index} < (IDX_W+1)'(CELL_TOTAL));
        a_next.cell_addr  = in_stage.item.cell_index[CELL_AW-1:0];
        a_next.cell_value = in_stage.item.cell_value;
        a_next.bin        = in_stage.item.bin;
        a_next.depth      = in_stage.item.depth;
        a_next.y0         = (y0_full > (ROW_W+1)'(CANVAS_HEIGHT - 1))
                          ? ROW_W'(CANVAS_HEIGHT - 1) : y0_full[ROW_W-1:0];
        a_next.yf         = yq[15:0];
        a_next.x0         = xq[XQ_W-1:16];
        a_next.xf         = xq[15:0];
    end

    // stage B: canvas access; writes land here so later reads see them
    always_comb
    begin
        y1 = (a_reg.y0 == ROW_W'(CANVAS_HEIGHT - 1)) ? a_reg.y0 : a_reg.y0 + 1'b1;
        x1 = (a_reg.x0 == COL_W'(CANVAS_WIDTH - 1)) ? '0 : a_reg.x0 + 1'b1;

        rd_addr[0] = CELL_AW'(a_reg.y0) * CELL_AW'(CANVAS_WIDTH) + CELL_AW'(a_reg.x0);
        rd_addr[1] = CELL_AW'(a_reg.y0) * CELL_AW'(CANVAS_WIDTH) + CELL_AW'(x1);
        rd_addr[2] = CELL_AW'(y1) * CELL_AW'(CANVAS_WIDTH) + CELL_AW'(a_reg.x0);
        rd_addr[3] = CELL_AW'(y1) * CELL_AW'(CANVAS_WIDTH) + CELL_AW'(x1);
        if (a_reg.op == OP_WRITE)
        begin
            rd_addr[0] = a_reg.cell_addr;
        end

        if (clear.active)
        begin
            wr_en   = ({1'b0, clear.addr} < (CLR_W+1)'(CELL_TOTAL));
            wr_addr = clear.addr[CELL_AW-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = en && a_reg.valid && (a_reg.op == OP_WRITE) && a_reg.wr_hit;
            wr_addr = a_reg.cell_addr;
            wr_data = a_reg.cell_value;
        end

        b_next            = '0;
        b_next.valid      = a_reg.valid;
        b_next.op         = a_reg.op;
        b_next.wr_hit     = a_reg.wr_hit;
        b_next.wr_nonzero = (a_reg.cell_value != '0);
        b_next.bin        = a_reg.bin;
        b_next.depth      = a_reg.depth;
        b_next.yf         = a_reg.yf;
        b_next.xf         = a_reg.xf;
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_canvas
        smbg_ram #(
            .WIDTH (Q15_W),
            .DEPTH (CELL_TOTAL)
        ) u_canvas (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (en),
            .rd_addr (rd_addr[k]),
            .rd_data (rd_data[k])
        );
    end

    // stage C: count update for writes, horizontal weights for computes
    always_comb
    begin
        count_next = count_reg;
        if (en && b_reg.valid && (b_reg.op == OP_WRITE) && b_reg.wr_hit)
        begin
            if ((rd_data[0] != '0) && !b_reg.wr_nonzero)
            begin
                count_next = count_reg - 1'b1;
            end
            else if ((rd_data[0] == '0) && b_reg.wr_nonzero)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        wx0 = 17'd65536 - 17'(b_reg.xf);
        c_next          = '0;
        c_next.valid    = b_reg.valid && (b_reg.op == OP_COMPUTE);
        c_next.bin      = b_reg.bin;
        c_next.depth    = b_reg.depth;
        c_next.nonempty = (count_reg != '0);
        c_next.yf       = b_reg.yf;
        c_next.p00      = 33'(rd_data[0]) * 33'(wx0);
        c_next.p01      = 33'(rd_data[1]) * 33'(b_reg.xf);
        c_next.p10      = 33'(rd_data[2]) * 33'(wx0);
        c_next.p11      = 33'(rd_data[3]) * 33'(b_reg.xf);
    end

    // stage D: row sums; each is at most 2^31
    always_comb
    begin
        d_next          = '0;
        d_next.valid    = c_reg.valid;
        d_next.bin      = c_reg.bin;
        d_next.depth    = c_reg.depth;
        d_next.nonempty = c_reg.nonempty;
        d_next.yf       = c_reg.yf;
        d_next.upper    = 32'(c_reg.p00 + c_reg.p01);
        d_next.lower    = 32'(c_reg.p10 + c_reg.p11);
    end

    // stage E: vertical weights
    always_comb
    begin
        wy0             = 17'd65536 - 17'(d_reg.yf);
        e_next          = '0;
        e_next.valid    = d_reg.valid;
        e_next.bin      = d_reg.bin;
        e_next.depth    = d_reg.depth;
        e_next.nonempty = d_reg.nonempty;
        e_next.e0       = 49'(d_reg.upper) * 49'(wy0);
        e_next.e1       = 49'(d_reg.lower) * 49'(d_reg.yf);
    end

    // stage F: round to Q1.15, half up
    always_comb
    begin
        m_sum  = 50'(e_reg.e0) + 50'(e_reg.e1) + 50'h0_0000_8000_0000;
        m_full = m_sum[49:32];

        f_next          = '0;
        f_next.valid    = e_reg.valid;
        f_next.bin      = e_reg.bin;
        f_next.depth    = e_reg.depth;
        f_next.nonempty = e_reg.nonempty;
        f_next.mask     = (m_full > 18'(UNITY_Q15)) ? UNITY_Q15 : m_full[Q15_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
            f_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (en)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
                c_reg <= c_next;
                d_reg <= d_next;
                e_reg <= e_next;
                f_reg <= f_next;
            end
        end
    end

    assign out_mask = f_reg;

endmodule

`default_nettype wire

/* rtl/smbg_gain_update.sv */
// ----------------------------------------------------------------------------
// smbg_gain_update
// Target gain from depth and mask, and one-pole smoothing of the stored
// per-bin gain.
// ----------------------------------------------------------------------------
`default_nettype none

module smbg_gain_update
    import smbg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire clear_t clear,
    input  wire mask_t  in_mask,
    output result_t     out_result
);

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] target;
        logic             fwd;
    } tgt_t;

    tgt_t             g_reg, g_next;
    logic [Q15_W-1:0] last_gain_reg;
    logic [32:0]      cut_sum;
    logic [17:0]      cut;
    logic [Q15_W-1:0] gain_rd;
    logic [Q15_W-1:0] g_old;
    logic [32:0]      mix_sum;
    logic [16:0]      mix;
    logic [Q15_W-1:0] gain_new;
    logic             wr_en;
    logic [GAIN_AW-1:0] wr_addr;
    logic [Q15_W-1:0] wr_data;

    // stage G: target gain, read of the stored gain
    always_comb
    begin
        cut_sum = 33'(in_mask.depth) * 33'(in_mask.mask) + 33'd16384;
        cut     = cut_sum[32:15];

        g_next       = '0;
        g_next.valid = in_mask.valid;
        g_next.bin   = in_mask.bin;
        if (!in_mask.nonempty)
        begin
            g_next.target = UNITY_Q15;
        end
        else if (cut >= 18'(UNITY_Q15))
        begin
            g_next.target = '0;
        end
        else
        begin
            g_next.target = UNITY_Q15 - cut[Q15_W-1:0];
        end
        // same bin one item ahead: its write misses this read
        g_next.fwd = in_mask.valid && g_reg.valid && (in_mask.bin == g_reg.bin);
    end

    // stage H: smoothing and write-back
    always_comb
    begin
        g_old    = g_reg.fwd ? last_gain_reg : gain_rd;
        mix_sum  = 33'(32'(g_old) * 32'(KEEP_Q16))
                 + 33'(32'(g_reg.target) * 32'(SMOOTH_Q16)) + 33'd32768;
        mix      = mix_sum[32:16];
        gain_new = (mix > 17'(UNITY_Q15)) ? UNITY_Q15 : mix[Q15_W-1:0];

        if (clear.active)
        begin
            wr_en   = ({1'b0, clear.addr} < (CLR_W+1)'(GAIN_DEPTH));
            wr_addr = clear.addr[GAIN_AW-1:0];
            wr_data = UNITY_Q15;
        end
        else
        begin
            wr_en   = en && g_reg.valid;
            wr_addr = g_reg.bin[GAIN_AW-1:0];
            wr_data = gain_new;
        end
    end

    smbg_ram #(
        .WIDTH (Q15_W),
        .DEPTH (GAIN_DEPTH)
    ) u_gains (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (en),
        .rd_addr (in_mask.bin[GAIN_AW-1:0]),
        .rd_data (gain_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= '0;
        end
        else if (en)
        begin
            g_reg <= g_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && g_reg.valid)
        begin
            last_gain_reg <= gain_new;
        end
    end

    assign out_result.valid = g_reg.valid;
    assign out_result.bin   = g_reg.bin;
    assign out_result.gain  = gain_new;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives canvas writes and bin gain requests into spectral_mask_bin_gain and
// checks every returned gain against an in-bench model of canvas and gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import smbg_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    spectral_mask_bin_gain u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [Q15_W-1:0] gain;
    } gain_rec_t;

    logic [15:0] canvas_q [CELL_TOTAL];
    logic [15:0] gain_q [GAIN_DEPTH];
    int          filled_cells;
    gain_rec_t   gain_queue [$];
    int          mismatch_count;
    int          burst_left;
    int          hold_cycles;
    bit          timed_out;
    longint      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] cell_val(int col, int row);
        int idx;
        idx = row * CANVAS_WIDTH + col;
        if (idx >= CELL_TOTAL)
            return 0;
        return canvas_q[idx];
    endfunction

    function automatic logic [63:0] bilinear_mask(int bin, logic [15:0] scan);
        logic [63:0] fq, c, yq, yf, xq, xf, up, lo, m;
        int y0, y1, x0, x1;
        fq = (64'(bin) << 32) / HALF_SIZE;
        if (fq > (64'd1 << 32))
            fq = 64'd1 << 32;
        c = isqrt64(fq);
        if (c > 65536)
            c = 65536;
        yq = (65536 - c) * (CANVAS_HEIGHT - 1);
        y0 = int'(yq >> 16);
        if (y0 > CANVAS_HEIGHT - 1)
            y0 = CANVAS_HEIGHT - 1;
        y1 = (y0 + 1 > CANVAS_HEIGHT - 1) ? CANVAS_HEIGHT - 1 : y0 + 1;
        yf = yq & 64'hFFFF;
        xq = 64'(scan) * CANVAS_WIDTH;
        x0 = int'((xq >> 16) % CANVAS_WIDTH);
        x1 = (x0 + 1) % CANVAS_WIDTH;
        xf = xq & 64'hFFFF;
        up = cell_val(x0, y0) * (65536 - xf) + cell_val(x1, y0) * xf;
        lo = cell_val(x0, y1) * (65536 - xf) + cell_val(x1, y1) * xf;
        m = (up * (65536 - yf) + lo * yf + (64'd1 << 31)) >> 32;
        if (m > UNITY_Q15)
            m = UNITY_Q15;
        return m;
    endfunction

    // update the model for one accepted request
    task automatic predict_gain(op_t op, logic [11:0] idx, logic [15:0] val,
                                logic [10:0] bin_in, logic [15:0] depth,
                                logic [15:0] scan);
        logic [63:0] tgt, cut, nxt;
        logic [15:0] v;
        int bin;
        gain_rec_t rec;
        if (op == OP_WRITE)
        begin
            v = (val > UNITY_Q15) ? UNITY_Q15 : val;
            if (idx < CELL_TOTAL)
            begin
                if (canvas_q[idx] != 0 && v == 0)
                    filled_cells--;
                else if (canvas_q[idx] == 0 && v != 0)
                    filled_cells++;
                canvas_q[idx] = v;
            end
            return;
        end
        bin = (bin_in > HALF_SIZE) ? HALF_SIZE : int'(bin_in);
        tgt = UNITY_Q15;
        if (filled_cells != 0)
        begin
            cut = (64'(depth) * bilinear_mask(bin, scan) + 16384) >> 15;
            tgt = (cut >= UNITY_Q15) ? 0 : UNITY_Q15 - cut;
        end
        nxt = (64'(gain_q[bin]) * KEEP_Q16 + tgt * SMOOTH_Q16 + 32768) >> 16;
        if (nxt > UNITY_Q15)
            nxt = UNITY_Q15;
        gain_q[bin] = nxt[15:0];
        rec.bin = bin[10:0];
        rec.gain = nxt[15:0];
        gain_queue.push_back(rec);
    endtask

    // one request, bursty sender
    task automatic send_req(op_t op, logic [11:0] idx, logic [15:0] val,
                            logic [10:0] bin, logic [15:0] depth, logic [15:0] scan);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, scan, depth, bin, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_gain(op, idx, val, bin, depth, scan);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_sender();
        while (gain_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_compute(logic [10:0] bin, logic [15:0] depth, logic [15:0] scan);
        send_req(OP_COMPUTE, 12'($urandom), 16'($urandom), bin, depth, scan);
    endtask

    task automatic send_write(logic [11:0] idx, logic [15:0] val);
        send_req(OP_WRITE, idx, val, 11'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_empty_canvas();
        send_compute(11'd0, 16'd32768, 16'd0);
        send_compute(11'd1024, 16'hFFFF, 16'hFFFF);
        send_compute(11'h7FF, 16'd0, 16'd1234);
    endtask

    task automatic test_directed_edges();
        send_write(12'd0, 16'hFFFF);               // saturates to unity
        send_write(12'd4095, 16'd32768);           // bottom right corner
        send_write(12'd63, 16'd20000);             // last column of top row
        send_write(12'd4032, 16'd32767);           // first column of bottom row
        send_compute(11'd1024, 16'd32768, 16'd0);  // top row
        send_compute(11'd0, 16'd32768, 16'hFFFF);  // bottom row, column wraps
        send_compute(11'd1500, 16'hFFFF, 16'd1023);
        send_compute(11'd512, 16'd32768, 16'h8000);
        send_compute(11'd1, 16'd16384, 16'd65000);
        send_compute(11'd700, 16'd65535, 16'd100);
        send_write(12'd0, 16'd0);
        send_write(12'd4095, 16'd0);
        send_write(12'd63, 16'd0);
        send_write(12'd4032, 16'd0);
        // canvas empty again: target back to unity
        send_compute(11'd1024, 16'd32768, 16'd0);
        send_compute(11'd0, 16'd32768, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        logic [11:0] idx;
        logic [15:0] val;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                idx = 12'($urandom);
                case ($urandom_range(0, 4))
                    0: val = 16'd0;
                    1: val = 16'($urandom_range(32769, 65535));
                    2: val = 16'd32768;
                    default: val = 16'($urandom);
                endcase
                send_write(idx, val);
            end
            else
                send_compute(($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                         : 11'($urandom_range(0, 1024)),
                             ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 32768)),
                             16'($urandom));
        end
    endtask

    // receiver holds off long while the sender keeps offering requests
    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 60; i++)
            send_compute(11'($urandom_range(0, 1024)), 16'($urandom_range(0, 32768)),
                         16'($urandom));
        wait_drained();
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else if ((cycle_count / 200) % 3 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        gain_rec_t exp_rec;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (gain_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: bin %0d gain %0d",
                             m_axis_tdata[10:0], m_axis_tdata[26:11]);
            end
            else
            begin
                exp_rec = gain_queue.pop_front();
                if (m_axis_tdata[10:0] !== exp_rec.bin || m_axis_tdata[26:11] !== exp_rec.gain)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected bin %0d gain %0d, got bin %0d gain %0d",
                                 exp_rec.bin, exp_rec.gain,
                                 m_axis_tdata[10:0], m_axis_tdata[26:11]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        timed_out = 1'b0;
        mismatch_count = 0;
        filled_cells = 0;
        burst_left = 0;
        for (int i = 0; i < CELL_TOTAL; i++)
            canvas_q[i] = 16'd0;
        for (int i = 0; i < GAIN_DEPTH; i++)
            gain_q[i] = UNITY_Q15;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_canvas();
        test_directed_edges();
        test_random_traffic(700);
        test_backpressure();
        test_random_traffic(800);
        wait_drained();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && gain_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/smbg_pkg.sv
rtl/smbg_ram.sv
rtl/smbg_sqrt_pipe.sv
rtl/smbg_mask_sampler.sv
rtl/smbg_gain_update.sv
rtl/spectral_mask_bin_gain.sv
tb/testbench.sv
